// ===== design/tlvd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvd_pkg
// Shared types and constants of the TLV stream decoder.
// ----------------------------------------------------------------------------
package tlvd_pkg;

  // Header layout: two type bytes, then four length bytes.
  localparam int unsigned TYPE_BYTES = 2;
  localparam int unsigned HDR_BYTES  = 6;

  typedef enum logic [1:0] {
    KIND_VALUE   = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_TRUNC   = 2'd2,
    KIND_PARTIAL = 2'd3
  } kind_t;

  // One raw byte of the incoming buffer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } item_t;

  // One decoded result.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] record_type;
    logic [31:0] record_length;
    logic [7:0]  value_byte;
    logic        record_done;
    logic        data_end;
  } result_t;

  // Hand-off from the parser to the result register.
  typedef struct packed {
    logic    valid;
    result_t res;
  } parse_out_t;

endpackage

// ===== design/tlvd_in_if.sv =====
// ----------------------------------------------------------------------------
// tlvd_in_if
// Byte request channel into the TLV stream decoder.
// ----------------------------------------------------------------------------
interface tlvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

// ===== design/tlvd_out_if.sv =====
// ----------------------------------------------------------------------------
// tlvd_out_if
// Result request channel out of the TLV stream decoder.
// ----------------------------------------------------------------------------
interface tlvd_out_if import tlvd_pkg::*; ;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] record_type;
  logic [31:0] record_length;
  logic [7:0]  value_byte;
  logic        record_done;
  logic        data_end;

  modport source (output valid, output kind, output record_type, output record_length,
                  output value_byte, output record_done, output data_end, input ready);
  modport sink   (input valid, input kind, input record_type, input record_length,
                  input value_byte, input record_done, input data_end, output ready);
endinterface

// ===== design/tlvd_in_stage.sv =====
// ----------------------------------------------------------------------------
// tlvd_in_stage
// Input register: holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
module tlvd_in_stage import tlvd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tlvd_in_if.sink    bytes,
  input  logic       take,
  output logic       item_valid,
  output item_t      item
);

  assign bytes.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (bytes.ready) begin
      item_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      item <= '{data_byte: bytes.data_byte, buffer_end: bytes.buffer_end};
    end
  end

endmodule

// ===== design/tlvd_parser.sv =====
// ----------------------------------------------------------------------------
// tlvd_parser
// Header and value-phase state of the decoder, with the per-byte decision.
// ----------------------------------------------------------------------------
module tlvd_parser import tlvd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  item_t      item,
  output parse_out_t po
);

  logic [2:0]  header_count, header_count_next;
  logic        in_value, in_value_next;
  logic [15:0] type_shift, type_shift_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] bytes_left, bytes_left_next;

  logic [2:0]  hc_inc;
  logic [15:0] type_nx;
  logic [31:0] len_nx;
  logic        in_type;

  always_comb begin
    in_type = header_count < 3'(TYPE_BYTES);
    hc_inc  = header_count + 3'd1;
    type_nx = in_type ? {type_shift[7:0], item.data_byte} : type_shift;
    len_nx  = in_type ? length_shift : {length_shift[23:0], item.data_byte};

    header_count_next = header_count;
    in_value_next     = in_value;
    type_shift_next   = type_shift;
    length_shift_next = length_shift;
    bytes_left_next   = bytes_left;
    po                = '0;
    po.res.kind       = KIND_VALUE;

    if (in_value) begin
      po.valid             = 1'b1;
      po.res.record_type   = type_shift;
      po.res.record_length = length_shift;
      if (bytes_left[31:1] == 31'd0) begin
        // Last byte of the record, whether or not the buffer ends here.
        po.res.kind        = KIND_VALUE;
        po.res.value_byte  = item.data_byte;
        po.res.record_done = 1'b1;
        po.res.data_end    = item.buffer_end;
        header_count_next  = '0;
        in_value_next      = 1'b0;
        type_shift_next    = '0;
        length_shift_next  = '0;
        bytes_left_next    = '0;
      end else if (item.buffer_end) begin
        po.res.kind       = KIND_TRUNC;
        po.res.data_end   = 1'b1;
        header_count_next = '0;
        in_value_next     = 1'b0;
        type_shift_next   = '0;
        length_shift_next = '0;
        bytes_left_next   = '0;
      end else begin
        po.res.kind       = KIND_VALUE;
        po.res.value_byte = item.data_byte;
        bytes_left_next   = bytes_left - 32'd1;
      end
    end else if (hc_inc == 3'(HDR_BYTES)) begin
      if (len_nx == 32'd0) begin
        po.valid           = 1'b1;
        po.res.kind        = KIND_EMPTY;
        po.res.record_type = type_nx;
        po.res.record_done = 1'b1;
        po.res.data_end    = item.buffer_end;
        header_count_next  = '0;
        type_shift_next    = '0;
        length_shift_next  = '0;
      end else if (item.buffer_end) begin
        po.valid             = 1'b1;
        po.res.kind          = KIND_TRUNC;
        po.res.record_type   = type_nx;
        po.res.record_length = len_nx;
        po.res.data_end      = 1'b1;
        header_count_next    = '0;
        type_shift_next      = '0;
        length_shift_next    = '0;
      end else begin
        header_count_next = '0;
        in_value_next     = 1'b1;
        type_shift_next   = type_nx;
        length_shift_next = len_nx;
        bytes_left_next   = len_nx;
      end
    end else if (item.buffer_end) begin
      po.valid          = 1'b1;
      po.res.kind       = KIND_PARTIAL;
      po.res.data_end   = 1'b1;
      header_count_next = '0;
      type_shift_next   = '0;
      length_shift_next = '0;
    end else begin
      header_count_next = hc_inc;
      type_shift_next   = type_nx;
      length_shift_next = len_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      in_value     <= 1'b0;
      type_shift   <= '0;
      length_shift <= '0;
      bytes_left   <= '0;
    end else if (take) begin
      header_count <= header_count_next;
      in_value     <= in_value_next;
      type_shift   <= type_shift_next;
      length_shift <= length_shift_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule

// ===== design/tlvd_out_stage.sv =====
// ----------------------------------------------------------------------------
// tlvd_out_stage
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module tlvd_out_stage import tlvd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        free,
  tlvd_out_if.source  records
);

  result_t held;

  assign free = !records.valid || records.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      records.valid <= 1'b0;
    end else if (free) begin
      records.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

  assign records.kind          = held.kind;
  assign records.record_type   = held.record_type;
  assign records.record_length = held.record_length;
  assign records.value_byte    = held.value_byte;
  assign records.record_done   = held.record_done;
  assign records.data_end      = held.data_end;

endmodule

// ===== design/tlv_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tlv_stream_decoder
// Splits a byte stream into type-length-value records.
// ----------------------------------------------------------------------------
// Usage. Bytes arrive on the "bytes" channel, one request per byte, with
// buffer_end set on the last byte of a buffer. Each record is a two-byte
// big-endian type, a four-byte big-endian length and that many value bytes.
// Results leave on the "records" channel: every value byte tagged with its
// record's type and length, one empty-record result for a zero length, and
// where a buffer ends inside a record, a truncated-record or partial-header
// report. Header bytes that complete nothing produce no result.
// A byte accepted into the input register passes through the combinational
// parser step, and its result is loaded into the result register.
// Throughput is one byte per cycle while the receiver does not stall, set
// by the combinational parser step between those two registers.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of a header. When the receiver stalls, the result
// register holds its request and the parser halts; the input register still
// takes a byte if it is empty, after which ready on "bytes" drops until the
// receiver takes the pending result.
// ----------------------------------------------------------------------------
module tlv_stream_decoder import tlvd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tlvd_in_if.sink    bytes,
  tlvd_out_if.source records
);

  logic       item_valid;
  item_t      item;
  logic       out_free;
  logic       take;
  parse_out_t po;

  // The parser steps whenever a byte is waiting and the result register
  // can take whatever that byte produces.
  assign take = item_valid && out_free;

  tlvd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  tlvd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .po   (po)
  );

  // Only bytes that produce a result occupy the result register.
  tlvd_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (take && po.valid),
    .res     (po.res),
    .free    (out_free),
    .records (records)
  );

endmodule
